[hw/rtl/tcu_pkg.sv]
`timescale 1ns / 1ps

package tcu_pkg;

  localparam int COORD_BITS_DEF = 16;
  localparam int FRAC_BITS_DEF  = 16;
  localparam int IN_BITS        = 16;
  localparam int OUT_BITS       = 48;
  localparam int CENTROID_DIV   = 3;

  typedef enum logic [1:0] {
    OP_INCENTER = 2'd0,
    OP_CENTROID = 2'd1,
    OP_CIRCUM   = 2'd2,
    OP_ORTHO    = 2'd3
  } op_t;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_DEGEN = 2'd1;
  localparam logic [1:0] ST_SAT   = 2'd2;

  typedef struct packed {
    logic valid;
    op_t  op;
  } sq_ctl_t;

  typedef struct packed {
    logic valid;
    logic neg_x;
    logic neg_y;
    logic degen;
  } dv_ctl_t;

endpackage

[hw/rtl/tcu_sqrt_cell.sv]
`timescale 1ns / 1ps

module tcu_sqrt_cell
  import tcu_pkg::*;
#(
  parameter int ROOT_W = 33,
  parameter int PAY_W  = 8
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  sq_ctl_t                     in_ctl,
  input  logic [2:0][2*ROOT_W-1:0]    in_rad,
  input  logic [2:0][ROOT_W+1:0]      in_rem,
  input  logic [2:0][ROOT_W-1:0]      in_root,
  input  logic [PAY_W-1:0]            in_pay,
  output sq_ctl_t                     out_ctl,
  output logic [2:0][2*ROOT_W-1:0]    out_rad,
  output logic [2:0][ROOT_W+1:0]      out_rem,
  output logic [2:0][ROOT_W-1:0]      out_root,
  output logic [PAY_W-1:0]            out_pay
);

  localparam int RADW = 2 * ROOT_W;
  localparam int TW   = ROOT_W + 4;

  logic [2:0][TW-1:0]       tst;
  logic [2:0][TW-1:0]       trial;
  logic [2:0][TW-1:0]       diff;
  logic [2:0][RADW-1:0]     rad_nxt;
  logic [2:0][ROOT_W+1:0]   rem_nxt;
  logic [2:0][ROOT_W-1:0]   root_nxt;

  sq_ctl_t                  ctl_r;
  logic [2:0][RADW-1:0]     rad_r;
  logic [2:0][ROOT_W+1:0]   rem_r;
  logic [2:0][ROOT_W-1:0]   root_r;
  logic [PAY_W-1:0]         pay_r;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      tst[k]     = {in_rem[k], in_rad[k][RADW-1 -: 2]};
      trial[k]   = {2'b00, in_root[k], 2'b01};
      diff[k]    = tst[k] - trial[k];
      rad_nxt[k] = {in_rad[k][RADW-3:0], 2'b00};
      if (tst[k] >= trial[k]) begin
        rem_nxt[k]  = diff[k][ROOT_W+1:0];
        root_nxt[k] = {in_root[k][ROOT_W-2:0], 1'b1};
      end else begin
        rem_nxt[k]  = tst[k][ROOT_W+1:0];
        root_nxt[k] = {in_root[k][ROOT_W-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_r <= '0;
    end else begin
      ctl_r <= in_ctl;
    end
  end

  always_ff @(posedge clk) begin
    rad_r  <= rad_nxt;
    rem_r  <= rem_nxt;
    root_r <= root_nxt;
    pay_r  <= in_pay;
  end

  assign out_ctl  = ctl_r;
  assign out_rad  = rad_r;
  assign out_rem  = rem_r;
  assign out_root = root_r;
  assign out_pay  = pay_r;

endmodule

[hw/rtl/tcu_div_cell.sv]
`timescale 1ns / 1ps

module tcu_div_cell
  import tcu_pkg::*;
#(
  parameter int DEN_W = 40,
  parameter int QUO_W = 70
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  dv_ctl_t                 in_ctl,
  input  logic [DEN_W-1:0]        in_den,
  input  logic [1:0][DEN_W-1:0]   in_rem,
  input  logic [1:0][QUO_W-1:0]   in_dq,
  output dv_ctl_t                 out_ctl,
  output logic [DEN_W-1:0]        out_den,
  output logic [1:0][DEN_W-1:0]   out_rem,
  output logic [1:0][QUO_W-1:0]   out_dq
);

  logic [1:0][DEN_W:0]      tst;
  logic [1:0][DEN_W:0]      diff;
  logic [1:0][DEN_W-1:0]    rem_nxt;
  logic [1:0][QUO_W-1:0]    dq_nxt;

  dv_ctl_t                  ctl_r;
  logic [DEN_W-1:0]         den_r;
  logic [1:0][DEN_W-1:0]    rem_r;
  logic [1:0][QUO_W-1:0]    dq_r;

  always_comb begin
    for (int k = 0; k < 2; k++) begin
      tst[k]  = {in_rem[k], in_dq[k][QUO_W-1]};
      diff[k] = tst[k] - {1'b0, in_den};
      if (tst[k] >= {1'b0, in_den}) begin
        rem_nxt[k] = diff[k][DEN_W-1:0];
        dq_nxt[k]  = {in_dq[k][QUO_W-2:0], 1'b1};
      end else begin
        rem_nxt[k] = tst[k][DEN_W-1:0];
        dq_nxt[k]  = {in_dq[k][QUO_W-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_r <= '0;
    end else begin
      ctl_r <= in_ctl;
    end
  end

  always_ff @(posedge clk) begin
    den_r <= in_den;
    rem_r <= rem_nxt;
    dq_r  <= dq_nxt;
  end

  assign out_ctl = ctl_r;
  assign out_den = den_r;
  assign out_rem = rem_r;
  assign out_dq  = dq_r;

endmodule

[hw/rtl/triangle_center_unit.sv]
`timescale 1ns / 1ps
// Channel   Ports                                   Handshake
// input     in_op, in_{x,y}_{first,second,third}    start & !busy
// result    out_center_x, out_center_y, out_status  out_valid, one cycle
//
// One word is taken every cycle; busy stays low.
// The pipeline holds ROOT_W = COORD_BITS + FRAC_BITS + 1
// square root cells and QUO_W divider cells.
// Synchronous active-low reset clears the valid bits of every stage.
// The receiver cannot stall; each result is shown for exactly one cycle.

module triangle_center_unit
  import tcu_pkg::*;
#(
  parameter int COORD_BITS = COORD_BITS_DEF,
  parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  output logic                        busy,
  input  logic [1:0]                  in_op,
  input  logic signed [IN_BITS-1:0]   in_x_first,
  input  logic signed [IN_BITS-1:0]   in_y_first,
  input  logic signed [IN_BITS-1:0]   in_x_second,
  input  logic signed [IN_BITS-1:0]   in_y_second,
  input  logic signed [IN_BITS-1:0]   in_x_third,
  input  logic signed [IN_BITS-1:0]   in_y_third,
  output logic                        out_valid,
  output logic signed [OUT_BITS-1:0]  out_center_x,
  output logic signed [OUT_BITS-1:0]  out_center_y,
  output logic [1:0]                  out_status
);

  localparam int CW   = COORD_BITS;
  localparam int FW   = FRAC_BITS;
  localparam int OW   = CW + 1;
  localparam int MW   = 2 * OW;
  localparam int SW   = MW + 1;
  localparam int RW   = CW + FW + 1;
  localparam int RADW = 2 * RW;
  localparam int AW   = (CW + FW + 2 > SW) ? CW + FW + 2 : SW;
  localparam int BW   = CW + 1;
  localparam int LW   = AW / 2;
  localparam int HW   = AW - LW;
  localparam int LPW  = LW + 1 + BW;
  localparam int HPW  = HW + BW;
  localparam int NW   = AW + BW + 2;
  localparam int DW   = (CW + FW + 4 > SW + 2) ? CW + FW + 4 : SW + 2;
  localparam int QW   = NW + FW;
  localparam int QX   = ((QW > OUT_BITS) ? QW : OUT_BITS) + 1;
  localparam int PLW  = 6 * CW + 3 * SW;

  logic accept;
  assign busy   = 1'b0;
  assign accept = start && !busy;

  logic [2:0][IN_BITS-1:0] in_x;
  logic [2:0][IN_BITS-1:0] in_y;
  logic [2:0][CW-1:0]      ext_x;
  logic [2:0][CW-1:0]      ext_y;

  assign in_x = {in_x_third, in_x_second, in_x_first};
  assign in_y = {in_y_third, in_y_second, in_y_first};

  if (CW <= IN_BITS) begin : g_trunc
    for (genvar i = 0; i < 3; i++) begin : g_v
      assign ext_x[i] = in_x[i][CW-1:0];
      assign ext_y[i] = in_y[i][CW-1:0];
    end
  end else begin : g_zext
    for (genvar i = 0; i < 3; i++) begin : g_v
      assign ext_x[i] = {{(CW-IN_BITS){1'b0}}, in_x[i]};
      assign ext_y[i] = {{(CW-IN_BITS){1'b0}}, in_y[i]};
    end
  end

  // input register
  sq_ctl_t             s0_ctl_r;
  logic [2:0][CW-1:0]  s0_x_r;
  logic [2:0][CW-1:0]  s0_y_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_ctl_r <= '0;
    end else begin
      s0_ctl_r.valid <= accept;
      s0_ctl_r.op    <= op_t'(in_op);
    end
  end

  always_ff @(posedge clk) begin
    s0_x_r <= ext_x;
    s0_y_r <= ext_y;
  end

  // operand select and products
  logic signed [OW-1:0] ex [3];
  logic signed [OW-1:0] ey [3];
  logic signed [OW-1:0] dx12, dx13, dx23, dy12, dy13, dy23;
  logic signed [OW-1:0] sx12, sx13, sy12, sy13;
  logic signed [OW-1:0] ma [6];
  logic signed [OW-1:0] mb [6];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      ex[i] = OW'($signed(s0_x_r[i]));
      ey[i] = OW'($signed(s0_y_r[i]));
    end
    dx12 = ex[0] - ex[1];
    dx13 = ex[0] - ex[2];
    dx23 = ex[1] - ex[2];
    dy12 = ey[0] - ey[1];
    dy13 = ey[0] - ey[2];
    dy23 = ey[1] - ey[2];
    sx12 = ex[0] + ex[1];
    sx13 = ex[0] + ex[2];
    sy12 = ey[0] + ey[1];
    sy13 = ey[0] + ey[2];
    for (int i = 0; i < 6; i++) begin
      ma[i] = '0;
      mb[i] = '0;
    end
    case (s0_ctl_r.op)
      OP_INCENTER: begin
        ma[0] = dx23; mb[0] = dx23;
        ma[1] = dy23; mb[1] = dy23;
        ma[2] = dx13; mb[2] = dx13;
        ma[3] = dy13; mb[3] = dy13;
        ma[4] = dx12; mb[4] = dx12;
        ma[5] = dy12; mb[5] = dy12;
      end
      OP_CIRCUM: begin
        ma[0] = dx12; mb[0] = sx12;
        ma[1] = dy12; mb[1] = sy12;
        ma[2] = dx13; mb[2] = sx13;
        ma[3] = dy13; mb[3] = sy13;
        ma[4] = dx12; mb[4] = dy13;
        ma[5] = dx13; mb[5] = dy12;
      end
      OP_ORTHO: begin
        ma[0] = ex[1]; mb[0] = dx13;
        ma[1] = ey[1]; mb[1] = dy13;
        ma[2] = ex[0]; mb[2] = dx23;
        ma[3] = ey[0]; mb[3] = dy23;
        ma[4] = dx23;  mb[4] = dy13;
        ma[5] = dy23;  mb[5] = dx13;
      end
      default: ;
    endcase
  end

  sq_ctl_t              s1_ctl_r;
  logic [2:0][CW-1:0]   s1_x_r;
  logic [2:0][CW-1:0]   s1_y_r;
  logic signed [MW-1:0] s1_m_r [6];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_ctl_r <= '0;
    end else begin
      s1_ctl_r <= s0_ctl_r;
    end
  end

  always_ff @(posedge clk) begin
    s1_x_r <= s0_x_r;
    s1_y_r <= s0_y_r;
    for (int i = 0; i < 6; i++) begin
      s1_m_r[i] <= ma[i] * mb[i];
    end
  end

  // pair sums
  sq_ctl_t             s2_ctl_r;
  logic [2:0][CW-1:0]  s2_x_r;
  logic [2:0][CW-1:0]  s2_y_r;
  logic [2:0][SW-1:0]  s2_s_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_ctl_r <= '0;
    end else begin
      s2_ctl_r <= s1_ctl_r;
    end
  end

  always_ff @(posedge clk) begin
    s2_x_r    <= s1_x_r;
    s2_y_r    <= s1_y_r;
    s2_s_r[0] <= SW'(s1_m_r[0]) + SW'(s1_m_r[1]);
    s2_s_r[1] <= SW'(s1_m_r[2]) + SW'(s1_m_r[3]);
    if (s1_ctl_r.op == OP_INCENTER) begin
      s2_s_r[2] <= SW'(s1_m_r[4]) + SW'(s1_m_r[5]);
    end else begin
      s2_s_r[2] <= SW'(s1_m_r[4]) - SW'(s1_m_r[5]);
    end
  end

  // square root chain, three roots in parallel (side lengths for the incenter)
  sq_ctl_t               sq_ctl  [RW+1];
  logic [2:0][RADW-1:0]  sq_rad  [RW+1];
  logic [2:0][RW+1:0]    sq_rem  [RW+1];
  logic [2:0][RW-1:0]    sq_root [RW+1];
  logic [PLW-1:0]        sq_pay  [RW+1];

  always_comb begin
    sq_ctl[0] = s2_ctl_r;
    for (int k = 0; k < 3; k++) begin
      sq_rad[0][k] = RADW'($unsigned(s2_s_r[k])) << (2 * FW);
    end
    sq_rem[0]  = '0;
    sq_root[0] = '0;
    sq_pay[0]  = {s2_x_r, s2_y_r, s2_s_r};
  end

  for (genvar g = 0; g < RW; g++) begin : g_sq
    tcu_sqrt_cell #(
      .ROOT_W (RW),
      .PAY_W  (PLW)
    ) u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .in_ctl   (sq_ctl[g]),
      .in_rad   (sq_rad[g]),
      .in_rem   (sq_rem[g]),
      .in_root  (sq_root[g]),
      .in_pay   (sq_pay[g]),
      .out_ctl  (sq_ctl[g+1]),
      .out_rad  (sq_rad[g+1]),
      .out_rem  (sq_rem[g+1]),
      .out_root (sq_root[g+1]),
      .out_pay  (sq_pay[g+1])
    );
  end

  // numerator operand select
  logic [2:0][CW-1:0]   t_x;
  logic [2:0][CW-1:0]   t_y;
  logic [2:0][SW-1:0]   t_s;
  logic [2:0][RW-1:0]   end_root;
  logic signed [BW-1:0] xe [3];
  logic signed [BW-1:0] ye [3];
  logic signed [AW-1:0] a_nxt  [3];
  logic signed [BW-1:0] bx_nxt [3];
  logic signed [BW-1:0] by_nxt [3];
  logic signed [DW-1:0] den_nxt;

  assign t_x      = sq_pay[RW][PLW-1 -: 3*CW];
  assign t_y      = sq_pay[RW][PLW-1-3*CW -: 3*CW];
  assign t_s      = sq_pay[RW][3*SW-1:0];
  assign end_root = sq_root[RW];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      xe[i]     = BW'($signed(t_x[i]));
      ye[i]     = BW'($signed(t_y[i]));
      a_nxt[i]  = '0;
      bx_nxt[i] = xe[i];
      by_nxt[i] = ye[i];
    end
    den_nxt = '0;
    case (sq_ctl[RW].op)
      OP_INCENTER: begin
        for (int i = 0; i < 3; i++) begin
          a_nxt[i] = AW'(end_root[i]);
        end
        den_nxt = DW'(end_root[0]) + DW'(end_root[1]) + DW'(end_root[2]);
      end
      OP_CENTROID: begin
        for (int i = 0; i < 3; i++) begin
          a_nxt[i] = AW'(1);
        end
        den_nxt = DW'(CENTROID_DIV);
      end
      OP_CIRCUM: begin
        a_nxt[0]  = AW'($signed(t_s[0]));
        a_nxt[1]  = AW'($signed(t_s[1]));
        bx_nxt[0] = ye[0] - ye[2];
        bx_nxt[1] = ye[1] - ye[0];
        bx_nxt[2] = '0;
        by_nxt[0] = xe[2] - xe[0];
        by_nxt[1] = xe[0] - xe[1];
        by_nxt[2] = '0;
        den_nxt   = DW'($signed(t_s[2])) + DW'($signed(t_s[2]));
      end
      OP_ORTHO: begin
        a_nxt[0]  = AW'($signed(t_s[0]));
        a_nxt[1]  = AW'($signed(t_s[1]));
        bx_nxt[0] = ye[2] - ye[1];
        bx_nxt[1] = ye[0] - ye[2];
        bx_nxt[2] = '0;
        by_nxt[0] = xe[2] - xe[1];
        by_nxt[1] = xe[0] - xe[2];
        by_nxt[2] = '0;
        den_nxt   = DW'($signed(t_s[2]));
      end
      default: ;
    endcase
  end

  sq_ctl_t              n0_ctl_r;
  logic signed [AW-1:0] n0_a_r  [3];
  logic signed [BW-1:0] n0_bx_r [3];
  logic signed [BW-1:0] n0_by_r [3];
  logic signed [DW-1:0] n0_den_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      n0_ctl_r <= '0;
    end else begin
      n0_ctl_r <= sq_ctl[RW];
    end
  end

  always_ff @(posedge clk) begin
    n0_a_r   <= a_nxt;
    n0_bx_r  <= bx_nxt;
    n0_by_r  <= by_nxt;
    n0_den_r <= den_nxt;
  end

  // split products
  sq_ctl_t               n1_ctl_r;
  logic signed [LPW-1:0] n1_plx_r [3];
  logic signed [HPW-1:0] n1_phx_r [3];
  logic signed [LPW-1:0] n1_ply_r [3];
  logic signed [HPW-1:0] n1_phy_r [3];
  logic signed [DW-1:0]  n1_den_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      n1_ctl_r <= '0;
    end else begin
      n1_ctl_r <= n0_ctl_r;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      n1_plx_r[i] <= $signed({1'b0, n0_a_r[i][LW-1:0]}) * n0_bx_r[i];
      n1_phx_r[i] <= $signed(n0_a_r[i][AW-1:LW]) * n0_bx_r[i];
      n1_ply_r[i] <= $signed({1'b0, n0_a_r[i][LW-1:0]}) * n0_by_r[i];
      n1_phy_r[i] <= $signed(n0_a_r[i][AW-1:LW]) * n0_by_r[i];
    end
    n1_den_r <= n0_den_r;
  end

  // numerator sums
  logic signed [NW-1:0] nx_sum;
  logic signed [NW-1:0] ny_sum;

  always_comb begin
    nx_sum = '0;
    ny_sum = '0;
    for (int i = 0; i < 3; i++) begin
      nx_sum = nx_sum + (NW'(n1_phx_r[i]) <<< LW) + NW'(n1_plx_r[i]);
      ny_sum = ny_sum + (NW'(n1_phy_r[i]) <<< LW) + NW'(n1_ply_r[i]);
    end
  end

  sq_ctl_t              n2_ctl_r;
  logic signed [NW-1:0] n2_nx_r;
  logic signed [NW-1:0] n2_ny_r;
  logic signed [DW-1:0] n2_den_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      n2_ctl_r <= '0;
    end else begin
      n2_ctl_r <= n1_ctl_r;
    end
  end

  always_ff @(posedge clk) begin
    n2_nx_r  <= nx_sum;
    n2_ny_r  <= ny_sum;
    n2_den_r <= n1_den_r;
  end

  // magnitudes and signs
  logic              dneg;
  logic [NW-1:0]     mag_x;
  logic [NW-1:0]     mag_y;
  logic [DW-1:0]     dmag;
  dv_ctl_t           n3_ctl_nxt;

  always_comb begin
    dneg  = n2_den_r[DW-1];
    mag_x = n2_nx_r[NW-1] ? NW'(-n2_nx_r) : NW'(n2_nx_r);
    mag_y = n2_ny_r[NW-1] ? NW'(-n2_ny_r) : NW'(n2_ny_r);
    dmag  = dneg ? DW'(-n2_den_r) : DW'(n2_den_r);
    n3_ctl_nxt.valid = n2_ctl_r.valid;
    n3_ctl_nxt.degen = (n2_den_r == '0);
    n3_ctl_nxt.neg_x = n2_nx_r[NW-1] ^ dneg;
    if (n2_ctl_r.op == OP_ORTHO) begin
      n3_ctl_nxt.neg_y = n2_ny_r[NW-1] ^ ~dneg;
    end else begin
      n3_ctl_nxt.neg_y = n2_ny_r[NW-1] ^ dneg;
    end
  end

  dv_ctl_t             n3_ctl_r;
  logic [DW-1:0]       n3_den_r;
  logic [1:0][QW-1:0]  n3_dq_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      n3_ctl_r <= '0;
    end else begin
      n3_ctl_r <= n3_ctl_nxt;
    end
  end

  always_ff @(posedge clk) begin
    n3_den_r   <= dmag;
    n3_dq_r[0] <= {mag_x, {FW{1'b0}}};
    n3_dq_r[1] <= {mag_y, {FW{1'b0}}};
  end

  // divider chain, x and y in parallel
  dv_ctl_t             dv_ctl [QW+1];
  logic [DW-1:0]       dv_den [QW+1];
  logic [1:0][DW-1:0]  dv_rem [QW+1];
  logic [1:0][QW-1:0]  dv_dq  [QW+1];

  assign dv_ctl[0] = n3_ctl_r;
  assign dv_den[0] = n3_den_r;
  assign dv_rem[0] = '0;
  assign dv_dq[0]  = n3_dq_r;

  for (genvar g = 0; g < QW; g++) begin : g_dv
    tcu_div_cell #(
      .DEN_W (DW),
      .QUO_W (QW)
    ) u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .in_ctl  (dv_ctl[g]),
      .in_den  (dv_den[g]),
      .in_rem  (dv_rem[g]),
      .in_dq   (dv_dq[g]),
      .out_ctl (dv_ctl[g+1]),
      .out_den (dv_den[g+1]),
      .out_rem (dv_rem[g+1]),
      .out_dq  (dv_dq[g+1])
    );
  end

  // saturate and apply sign
  logic [1:0]           negv;
  logic [1:0]           sat;
  logic [1:0][QX-1:0]   qe;
  logic [1:0][QX-1:0]   lim;
  logic [1:0][QX-1:0]   vsat;
  logic [1:0][QX-1:0]   res;

  always_comb begin
    negv = {dv_ctl[QW].neg_y, dv_ctl[QW].neg_x};
    for (int k = 0; k < 2; k++) begin
      qe[k]   = QX'(dv_dq[QW][k]);
      lim[k]  = (QX'(1) << (OUT_BITS - 1)) - QX'(!negv[k]);
      sat[k]  = qe[k] > lim[k];
      vsat[k] = sat[k] ? lim[k] : qe[k];
      res[k]  = negv[k] ? (QX'(0) - vsat[k]) : vsat[k];
    end
  end

  logic                 out_valid_r;
  logic [OUT_BITS-1:0]  out_x_r;
  logic [OUT_BITS-1:0]  out_y_r;
  logic [1:0]           out_status_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= dv_ctl[QW].valid;
    end
  end

  always_ff @(posedge clk) begin
    if (dv_ctl[QW].degen) begin
      out_x_r      <= '0;
      out_y_r      <= '0;
      out_status_r <= ST_DEGEN;
    end else begin
      out_x_r      <= res[0][OUT_BITS-1:0];
      out_y_r      <= res[1][OUT_BITS-1:0];
      out_status_r <= (|sat) ? ST_SAT : ST_OK;
    end
  end

  assign out_valid    = out_valid_r;
  assign out_center_x = out_x_r;
  assign out_center_y = out_y_r;
  assign out_status   = out_status_r;

endmodule
